@@ sv/lba_chs_pkg.sv @@
// types and constants for the lba/chs address translator
// no dependencies; used by lba_chs_translator_top
package lba_chs_pkg;

    localparam int LBA_W  = 32;
    localparam int CYL_W  = 16;
    localparam int GEO_W  = 8;
    localparam int IDX_W  = 8;

    // opcodes
    localparam logic OP_TO_CHS = 1'b0;
    localparam logic OP_TO_LBA = 1'b1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SPT   = 8'd0;
    localparam logic [IDX_W-1:0] REG_HEADS = 8'd1;

    localparam logic [GEO_W-1:0] SPT_RESET   = 8'd63;
    localparam logic [GEO_W-1:0] HEADS_RESET = 8'd16;

    typedef struct packed {
        logic             opcode;
        logic [LBA_W-1:0] block_number;
        logic [CYL_W-1:0] cylinder_in;
        logic [GEO_W-1:0] head_in;
        logic [GEO_W-1:0] sector_in;
    } t_req;

    typedef struct packed {
        logic [LBA_W-1:0] block_out;
        logic [CYL_W-1:0] cylinder_out;
        logic [GEO_W-1:0] head_out;
        logic [GEO_W-1:0] sector_out;
        logic             out_of_range;
    } t_rsp;

endpackage

@@ sv/lba_chs_translator_top.sv @@
// lba/chs address translator, fully pipelined
// depends on lba_chs_pkg
//
// usage:
//   input channel  i_valid / o_stall carries one t_req word; a word is taken
//   at a clock edge with i_valid high and o_stall low
//   output channel o_valid / i_stall carries one t_rsp word per request
//   config port i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data;
//   index 0 sectors per track, 1 heads per cylinder, others ignored
//   pipeline from accept to o_rsp: capture stage, 64 divide stages,
//   output register
//   throughput: one word per cycle while the output is not stalled, set by the bit-per-stage restoring
//   dividers (32 stages dividing by sectors, 32 dividing by heads)
//   reverse direction multiplies in stages 0 and 1, subtracts one into stage 2 and rides along after that
//   reset: pipeline empty, geometry 63 sectors, 16 heads
//   stall: when the output word is held by i_stall, the whole pipeline
//   freezes and o_stall rises; nothing is lost or repeated
//   config is meant to be written only while the pipeline is empty
module lba_chs_translator_top
    import lba_chs_pkg::*;
#(
    parameter int BLOCK_WIDTH    = 32,
    parameter int CYLINDER_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_req             i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [GEO_W-1:0] i_cfg_data
);

    // division steps: first lba / spt, then quotient / heads
    localparam int ND  = 2 * LBA_W;
    // width of (cyl*heads + head)*spt + sector
    localparam int VW  = CYL_W + 2 * GEO_W + 2;
    localparam int PW  = CYL_W + GEO_W + 1;

    // block number mask, also the wrapped / saturated block value
    localparam logic [LBA_W-1:0] LBA_MASK = (BLOCK_WIDTH >= LBA_W) ? {LBA_W{1'b1}} :
                                            LBA_W'((64'd1 << BLOCK_WIDTH) - 64'd1);
    localparam logic [CYL_W-1:0] CYL_SAT  = CYL_W'((64'd1 << CYLINDER_WIDTH) - 64'd1);

    // geometry registers
    logic [GEO_W-1:0] r_spt;
    logic [GEO_W-1:0] r_heads;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt   <= SPT_RESET;
            r_heads <= HEADS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_SPT) begin
                r_spt <= i_cfg_data;
            end else if (i_cfg_index == REG_HEADS) begin
                r_heads <= i_cfg_data;
            end
        end
    end

    // pipeline stage registers; stage k holds the state after k divide steps
    logic             r_vld  [0:ND];
    logic             r_op   [0:ND];
    logic             r_zero [0:ND];
    logic             r_flag [0:ND];
    logic [LBA_W-1:0] r_num  [0:ND];
    logic [GEO_W-1:0] r_rem  [0:ND];
    logic [GEO_W-1:0] r_sec  [0:ND];
    logic [VW-1:0]    r_aux  [0:ND];

    logic r_out_vld;
    t_rsp r_out;
    logic w_en;

    // global advance: freeze everything while the output word is held
    assign w_en    = !r_out_vld || !i_stall;
    assign o_stall = !w_en;

    // stage 0 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op[0]   <= i_req.opcode;
            r_zero[0] <= (r_spt == '0) || (r_heads == '0);
            r_flag[0] <= (r_spt == '0) || (r_heads == '0) ||
                         ((i_req.opcode == OP_TO_LBA) &&
                          ((i_req.sector_in == '0) || (i_req.sector_in > r_spt) ||
                           (i_req.head_in >= r_heads)));
            r_num[0]  <= i_req.block_number & LBA_MASK;
            r_rem[0]  <= '0;
            r_sec[0]  <= i_req.sector_in;
            // first product of the reverse direction: cyl*heads + head
            r_aux[0]  <= VW'(PW'(i_req.cylinder_in * r_heads) + PW'(i_req.head_in));
        end
    end

    genvar k;
    generate
        for (k = 0; k < ND; k++) begin : g_stage
            logic [GEO_W-1:0] w_div;
            logic [GEO_W-1:0] w_rem_in;
            logic [GEO_W:0]   w_trial;
            logic             w_bit;
            logic [VW-1:0]    w_vm1;
            logic             w_sat;
            logic [LBA_W-1:0] n_num;
            logic [GEO_W-1:0] n_rem;
            logic [GEO_W-1:0] n_sec;
            logic [VW-1:0]    n_aux;
            logic             n_flag;

            always_comb begin
                w_div    = (k < LBA_W) ? r_spt : r_heads;
                // second divide starts with a clean remainder
                w_rem_in = (k == LBA_W) ? '0 : r_rem[k];
                w_trial  = {w_rem_in, r_num[k][LBA_W-1]};
                w_bit    = (w_trial >= {1'b0, w_div});
                n_rem    = w_bit ? GEO_W'(w_trial - {1'b0, w_div}) : w_trial[GEO_W-1:0];
                n_num    = {r_num[k][LBA_W-2:0], w_bit};
                n_sec    = r_sec[k];
                n_aux    = r_aux[k];
                n_flag   = r_flag[k];
                w_vm1    = r_aux[k] - VW'(1);
                w_sat    = (BLOCK_WIDTH < VW) && ((w_vm1 >> BLOCK_WIDTH) != '0);
                if (k == LBA_W && r_op[k] == OP_TO_CHS) begin
                    // remainder of lba / spt gives the one-based sector
                    n_sec = r_rem[k] + GEO_W'(1);
                end
                if (k == 0) begin
                    n_aux = VW'(r_aux[k][PW-1:0] * r_spt) + VW'(r_sec[k]);
                end else if (k == 1) begin
                    if (r_aux[k] == '0) begin
                        n_aux = VW'(LBA_MASK);
                    end else if (w_sat) begin
                        n_aux  = VW'(LBA_MASK);
                        n_flag = r_flag[k] || (r_op[k] == OP_TO_LBA);
                    end else begin
                        n_aux = w_vm1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (w_en) begin
                    r_vld[k+1] <= r_vld[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_op[k+1]   <= r_op[k];
                    r_zero[k+1] <= r_zero[k];
                    r_flag[k+1] <= n_flag;
                    r_num[k+1]  <= n_num;
                    r_rem[k+1]  <= n_rem;
                    r_sec[k+1]  <= n_sec;
                    r_aux[k+1]  <= n_aux;
                end
            end
        end
    endgenerate

    // result assembly from the last divide stage
    t_rsp n_out;
    logic w_cyl_sat;

    always_comb begin
        n_out     = '0;
        w_cyl_sat = (r_num[ND] >> CYLINDER_WIDTH) != '0;
        if (r_zero[ND]) begin
            n_out.out_of_range = 1'b1;
        end else if (r_op[ND] == OP_TO_CHS) begin
            n_out.cylinder_out = w_cyl_sat ? CYL_SAT : r_num[ND][CYL_W-1:0];
            n_out.head_out     = r_rem[ND];
            n_out.sector_out   = r_sec[ND];
            n_out.out_of_range = w_cyl_sat;
        end else begin
            n_out.block_out    = r_aux[ND][LBA_W-1:0];
            n_out.out_of_range = r_flag[ND];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

endmodule

@@ test/tb_top.sv @@
// testbench for lba_chs_translator_top: random and directed address translations
// depends on lba_chs_pkg and lba_chs_translator_top; checks against an in-bench predictor
`timescale 1ns / 100ps

module tb_top;
    import lba_chs_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    t_req             i_req;
    logic             o_valid;
    logic             i_stall;
    t_rsp             o_rsp;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [GEO_W-1:0] i_cfg_data;

    // geometry as the predictor sees it
    logic [GEO_W-1:0] geo_spt;
    logic [GEO_W-1:0] geo_heads;
    bit               hold_off;
    int               n_errors;

    // scoreboard: translates each accepted request and checks responses in order
    class addr_scoreboard;
        t_rsp pending[$];
        int   errors;

        function t_rsp translate(t_req rq, logic [GEO_W-1:0] spt, logic [GEO_W-1:0] hds);
            t_rsp           rs;
            logic [63:0]    lba;
            logic [63:0]    cyl;
            logic [63:0]    v;
            rs = '0;
            if (spt == 0 || hds == 0) begin
                rs.out_of_range = 1'b1;
            end else if (rq.opcode == OP_TO_CHS) begin
                lba = 64'(rq.block_number);
                cyl = lba / (64'(hds) * 64'(spt));
                rs.sector_out = GEO_W'(lba % 64'(spt) + 1);
                rs.head_out = GEO_W'((lba / 64'(spt)) % 64'(hds));
                if (cyl > 64'hFFFF) begin
                    cyl = 64'hFFFF;
                    rs.out_of_range = 1'b1;
                end
                rs.cylinder_out = CYL_W'(cyl);
            end else begin
                v = (64'(rq.cylinder_in) * 64'(hds) + 64'(rq.head_in)) * 64'(spt)
                    + 64'(rq.sector_in);
                if (rq.sector_in == 0 || rq.sector_in > spt || rq.head_in >= hds)
                    rs.out_of_range = 1'b1;
                if (v == 0) begin
                    rs.block_out = '1;
                end else begin
                    v = v - 1;
                    if (v > 64'hFFFF_FFFF) begin
                        v = 64'hFFFF_FFFF;
                        rs.out_of_range = 1'b1;
                    end
                    rs.block_out = LBA_W'(v);
                end
            end
            return rs;
        endfunction

        function void note_request(t_req rq, logic [GEO_W-1:0] spt, logic [GEO_W-1:0] hds);
            pending.push_back(translate(rq, spt, hds));
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.block_out !== want.block_out)
                $display("%0t: block_out exp %h got %h", $time, want.block_out, got.block_out);
            if (got.cylinder_out !== want.cylinder_out)
                $display("%0t: cylinder_out exp %h got %h", $time, want.cylinder_out,
                         got.cylinder_out);
            if (got.head_out !== want.head_out)
                $display("%0t: head_out exp %h got %h", $time, want.head_out, got.head_out);
            if (got.sector_out !== want.sector_out)
                $display("%0t: sector_out exp %h got %h", $time, want.sector_out, got.sector_out);
            if (got.out_of_range !== want.out_of_range)
                $display("%0t: out_of_range exp %b got %b", $time, want.out_of_range,
                         got.out_of_range);
            if (got !== want)
                errors++;
        endfunction
    endclass

    addr_scoreboard sb;

    lba_chs_translator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // monitor: note accepted requests and check accepted responses
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_request(i_req, geo_spt, geo_heads);
            if (o_valid && !i_stall)
                sb.check_response(o_rsp);
        end
    end

    // receiver: random stall pattern, long hold-off on request
    initial begin
        int mode;
        i_stall = 1'b0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off)
                i_stall <= 1'b1;
            else begin
                if ($urandom_range(0, 63) == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // one config write; geometry updated for the predictor on acceptance
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [GEO_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_SPT)
            geo_spt = val;
        else if (idx == REG_HEADS)
            geo_heads = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one word and hold it until taken
    task automatic send_word(t_req rq);
        i_valid <= 1'b1;
        i_req   <= rq;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // drain everything, then let the pipeline settle before touching config
    task automatic wait_empty();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_req rand_req(bit in_geo);
        t_req rq;
        rq.opcode = 1'($urandom_range(0, 1));
        rq.block_number = $urandom();
        rq.cylinder_in = CYL_W'($urandom());
        rq.head_in = GEO_W'($urandom());
        rq.sector_in = GEO_W'($urandom());
        case ($urandom_range(0, 3))
            0: rq.block_number = $urandom_range(0, 70000);
            1: rq.cylinder_in = CYL_W'($urandom_range(0, 1100));
            default: ;
        endcase
        if (in_geo && geo_spt != 0 && geo_heads != 0) begin
            rq.head_in = GEO_W'($urandom_range(0, geo_heads - 1));
            rq.sector_in = GEO_W'($urandom_range(1, geo_spt));
        end
        return rq;
    endfunction

    // random burst traffic with gaps
    task automatic random_phase(int count);
        int   left;
        int   burst;
        t_req rq;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                rq = rand_req($urandom_range(0, 3) != 0);
                send_word(rq);
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 8));
        end
        i_valid <= 1'b0;
    endtask

    // always followed directly by random traffic, which takes over i_valid
    task automatic directed_phase();
        t_req rq;
        rq = '0;
        // forward extremes
        rq.opcode = OP_TO_CHS;
        rq.block_number = 32'd0;           send_word(rq);
        rq.block_number = 32'd62;          send_word(rq);
        rq.block_number = 32'd63;          send_word(rq);
        rq.block_number = 32'd1007;        send_word(rq);
        rq.block_number = 32'd1008;        send_word(rq);
        // cylinder overflow saturates
        rq.block_number = 32'hFFFF_FFFF;   send_word(rq);
        rq.block_number = 32'd66060288;    send_word(rq);
        // reverse direction
        rq = '0;
        rq.opcode = OP_TO_LBA;
        // all zero: underflow wraps and flags
        send_word(rq);
        rq.sector_in = 8'd1;               send_word(rq);
        rq.sector_in = 8'd63;              send_word(rq);
        rq.sector_in = 8'd64;              send_word(rq);
        rq.sector_in = 8'd255;             send_word(rq);
        rq.sector_in = 8'd1; rq.head_in = 8'd15; send_word(rq);
        rq.head_in = 8'd16;                send_word(rq);
        rq.head_in = 8'd255;               send_word(rq);
        rq.head_in = 8'd15; rq.cylinder_in = 16'hFFFF; rq.sector_in = 8'd63;
        send_word(rq);
        rq.block_number = 32'hFFFF_FFFF;   send_word(rq);
    endtask

    initial begin
        sb = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        geo_spt     = SPT_RESET;
        geo_heads   = HEADS_RESET;
        hold_off    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry
        directed_phase();

        // long receiver hold-off while the sender keeps pushing
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(150);
        join
        wait_empty();

        // largest geometry, 255 sectors and 255 heads
        write_reg(REG_SPT, 8'd255);
        write_reg(REG_HEADS, 8'd255);
        write_reg(8'd7, 8'd1);   // unknown index, ignored
        idle_cycles(1);
        directed_phase();
        random_phase(250);
        wait_empty();

        // smallest geometry: cylinder saturates for most block numbers
        write_reg(REG_SPT, 8'd1);
        write_reg(REG_HEADS, 8'd1);
        idle_cycles(1);
        random_phase(200);
        wait_empty();

        // zero geometry: everything flagged
        write_reg(REG_SPT, 8'd0);
        idle_cycles(1);
        random_phase(40);
        wait_empty();
        write_reg(REG_SPT, 8'd17);
        write_reg(REG_HEADS, 8'd0);
        idle_cycles(1);
        random_phase(40);
        wait_empty();

        // four random geometries
        repeat (4) begin
            write_reg(REG_SPT, 8'($urandom_range(1, 255)));
            write_reg(REG_HEADS, 8'($urandom_range(1, 255)));
            idle_cycles(1);
            random_phase(130);
            wait_empty();
        end

        n_errors = sb.errors + sb.pending.size();
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
